@@ sv/stepper_press_cycle_sequencer_defines.svh @@
// ---------------------------------------------------------------------------
// Stepper press cycle sequencer assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef STEPPER_PRESS_CYCLE_SEQUENCER_DEFINES_SVH
`define STEPPER_PRESS_CYCLE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SPCS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("spcs assertion failed");
`define SPCS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("spcs assertion failed");
`else
`define SPCS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define SPCS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

@@ sv/spcs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper press cycle sequencer package
// Widths, register indexes, reset values, phase codes and shared structs.
// ---------------------------------------------------------------------------
package spcs_pkg;

    localparam int TIMER_WIDTH     = 32;
    localparam int COUNT_WIDTH     = 32;
    localparam int DUR_WIDTH       = 32;
    localparam int STEP_WIDTH      = 8;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int OUT_COUNT_WIDTH = 32;
    localparam int CMP_WIDTH       =
        ((TIMER_WIDTH > DUR_WIDTH) ? TIMER_WIDTH : DUR_WIDTH) + 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NUM_STEPS     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PULSE_GAP     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMPRESS      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REST          = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_COUNT = 3'd5;

    localparam logic [STEP_WIDTH-1:0]  RST_NUM_STEPS     = 8'd20;
    localparam logic [DUR_WIDTH-1:0]   RST_PULSE_HIGH    = 32'd55;
    localparam logic [DUR_WIDTH-1:0]   RST_PULSE_GAP     = 32'd9000;
    localparam logic [DUR_WIDTH-1:0]   RST_COMPRESS      = 32'd10000000;
    localparam logic [DUR_WIDTH-1:0]   RST_REST          = 32'd5000000;
    localparam logic [OUT_COUNT_WIDTH-1:0] RST_INITIAL_COUNT = 32'd0;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ENG_HIGH = 3'd1,
        PH_ENG_LOW  = 3'd2,
        PH_COMPRESS = 3'd3,
        PH_DIS_HIGH = 3'd4,
        PH_DIS_LOW  = 3'd5,
        PH_REST     = 3'd6
    } phase_t;

    typedef struct packed {
        logic [STEP_WIDTH-1:0]      num_steps;
        logic [DUR_WIDTH-1:0]       pulse_high_ticks;
        logic [DUR_WIDTH-1:0]       pulse_gap_ticks;
        logic [DUR_WIDTH-1:0]       compress_ticks;
        logic [DUR_WIDTH-1:0]       rest_ticks;
        logic [OUT_COUNT_WIDTH-1:0] initial_count;
    } cfg_t;

    typedef struct packed {
        logic                       engage_pin;
        logic                       disengage_pin;
        logic                       cycle_running;
        logic [OUT_COUNT_WIDTH-1:0] completed_cycles;
        logic                       count_updated;
        logic                       stopped;
    } result_t;

endpackage

@@ sv/spcs_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper press cycle sequencer channels
// Valid/ready interfaces for the tick items and the result items.
// ---------------------------------------------------------------------------
interface spcs_tick_if;
    logic valid;
    logic ready;
    logic start_request;
    logic stop_request;

    modport source (output valid, output start_request, output stop_request, input ready);
    modport sink (input valid, input start_request, input stop_request, output ready);
endinterface

interface spcs_result_if;
    logic        valid;
    logic        ready;
    logic        engage_pin;
    logic        disengage_pin;
    logic        cycle_running;
    logic [31:0] completed_cycles;
    logic        count_updated;
    logic        stopped;

    modport source (
        output valid, output engage_pin, output disengage_pin, output cycle_running,
        output completed_cycles, output count_updated, output stopped, input ready
    );
    modport sink (
        input valid, input engage_pin, input disengage_pin, input cycle_running,
        input completed_cycles, input count_updated, input stopped, output ready
    );
endinterface

@@ sv/stepper_press_cycle_sequencer.sv @@
`timescale 1ns / 1ps
`include "stepper_press_cycle_sequencer_defines.svh"
// Latency: a result item appears in the cycle after its tick item is accepted.
// Throughput: one tick item per cycle when the result is not stalled; the core's
//   phase step is a single pass from state register to result register.
// Reset: rst_n clears the phase to idle, timer, step count and cycle count to
//   zero, and loads the configuration registers with their default values.
// ---------------------------------------------------------------------------
// Stepper press cycle sequencer
// Configuration registers, tick handshake and registered result stage around
// the press cycle core.
// ---------------------------------------------------------------------------
module stepper_press_cycle_sequencer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    spcs_tick_if.sink                            tick,
    spcs_result_if.source                        result,
    input  logic                                 cfg_we,
    input  logic [spcs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [spcs_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
    import spcs_pkg::*;

    cfg_t    cfg_reg;
    result_t core_res;
    result_t res_reg;
    logic    res_valid_reg;
    logic    tick_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_steps        <= RST_NUM_STEPS;
            cfg_reg.pulse_high_ticks <= RST_PULSE_HIGH;
            cfg_reg.pulse_gap_ticks  <= RST_PULSE_GAP;
            cfg_reg.compress_ticks   <= RST_COMPRESS;
            cfg_reg.rest_ticks       <= RST_REST;
            cfg_reg.initial_count    <= RST_INITIAL_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_STEPS:     cfg_reg.num_steps        <= cfg_wdata[STEP_WIDTH-1:0];
                CFG_PULSE_HIGH:    cfg_reg.pulse_high_ticks <= DUR_WIDTH'(cfg_wdata);
                CFG_PULSE_GAP:     cfg_reg.pulse_gap_ticks  <= DUR_WIDTH'(cfg_wdata);
                CFG_COMPRESS:      cfg_reg.compress_ticks   <= DUR_WIDTH'(cfg_wdata);
                CFG_REST:          cfg_reg.rest_ticks       <= DUR_WIDTH'(cfg_wdata);
                CFG_INITIAL_COUNT: cfg_reg.initial_count    <= OUT_COUNT_WIDTH'(cfg_wdata);
                default:           ;
            endcase
        end
    end

    assign tick.ready  = !res_valid_reg || result.ready;
    assign tick_accept = tick.valid && tick.ready;

    spcs_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (tick_accept),
        .start_request (tick.start_request),
        .stop_request  (tick.stop_request),
        .cfg           (cfg_reg),
        .res           (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (tick.ready)
        begin
            res_valid_reg <= tick.valid;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            res_reg <= core_res;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.engage_pin       = res_reg.engage_pin;
    assign result.disengage_pin    = res_reg.disengage_pin;
    assign result.cycle_running    = res_reg.cycle_running;
    assign result.completed_cycles = res_reg.completed_cycles;
    assign result.count_updated    = res_reg.count_updated;
    assign result.stopped          = res_reg.stopped;

    `SPCS_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, tick_accept, res_valid_reg)
    `SPCS_ASSERT_IMPLIES(a_pins_exclusive, clk, rst_n, res_valid_reg,
        !(res_reg.engage_pin && res_reg.disengage_pin))
    `SPCS_ASSERT_IMPLIES(a_pin_while_running, clk, rst_n,
        res_valid_reg && (res_reg.engage_pin || res_reg.disengage_pin),
        res_reg.cycle_running)
    `SPCS_ASSERT_IMPLIES(a_update_not_running, clk, rst_n,
        res_valid_reg && res_reg.count_updated, !res_reg.cycle_running)

endmodule

@@ sv/spcs_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stepper press cycle sequencer core
// Phase state machine, phase timer, step count and cycle counter; advances
// by one tick per accepted item.
// ---------------------------------------------------------------------------
module spcs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             start_request,
    input  logic             stop_request,
    input  spcs_pkg::cfg_t   cfg,
    output spcs_pkg::result_t res
);
    import spcs_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [STEP_WIDTH-1:0]   steps_reg, steps_next;
    logic [TIMER_WIDTH-1:0]  timer_reg, timer_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [DUR_WIDTH-1:0]    dur;
    logic [STEP_WIDTH-1:0]   steps_inc;
    logic                    phase_done;
    logic                    updated;
    logic                    stopped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            steps_reg <= '0;
            timer_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            steps_reg <= steps_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_ENG_HIGH, PH_DIS_HIGH: dur = cfg.pulse_high_ticks;
            PH_ENG_LOW, PH_DIS_LOW:   dur = cfg.pulse_gap_ticks;
            PH_COMPRESS:              dur = cfg.compress_ticks;
            PH_REST:                  dur = cfg.rest_ticks;
            default:                  dur = '0;
        endcase
    end

    assign phase_done = (CMP_WIDTH'(timer_reg) + CMP_WIDTH'(1) >= CMP_WIDTH'(dur))
                        || (timer_reg == {TIMER_WIDTH{1'b1}});
    assign steps_inc  = steps_reg + STEP_WIDTH'(1);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        steps_next = steps_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        updated    = 1'b0;
        stopped    = 1'b0;
        unique case (phase_reg)
            PH_ENG_HIGH, PH_DIS_HIGH:
            begin
                if (phase_done)
                begin
                    phase_next = (phase_reg == PH_ENG_HIGH) ? PH_ENG_LOW : PH_DIS_LOW;
                    timer_next = '0;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_WIDTH'(1);
                end
            end
            PH_ENG_LOW, PH_DIS_LOW:
            begin
                if (phase_done)
                begin
                    timer_next = '0;
                    if (steps_inc >= cfg.num_steps)
                    begin
                        steps_next = '0;
                        phase_next = (phase_reg == PH_ENG_LOW) ? PH_COMPRESS : PH_REST;
                    end
                    else
                    begin
                        steps_next = steps_inc;
                        phase_next = (phase_reg == PH_ENG_LOW) ? PH_ENG_HIGH : PH_DIS_HIGH;
                    end
                end
                else
                begin
                    timer_next = timer_reg + TIMER_WIDTH'(1);
                end
            end
            PH_COMPRESS:
            begin
                if (phase_done)
                begin
                    steps_next = '0;
                    timer_next = '0;
                    phase_next = (cfg.num_steps == '0) ? PH_REST : PH_DIS_HIGH;
                end
                else
                begin
                    timer_next = timer_reg + TIMER_WIDTH'(1);
                end
            end
            PH_REST:
            begin
                if (phase_done)
                begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                    updated    = 1'b1;
                    steps_next = '0;
                    timer_next = '0;
                    if (stop_request)
                    begin
                        phase_next = PH_IDLE;
                        stopped    = 1'b1;
                    end
                    else
                    begin
                        phase_next = (cfg.num_steps == '0) ? PH_COMPRESS : PH_ENG_HIGH;
                    end
                end
                else
                begin
                    timer_next = timer_reg + TIMER_WIDTH'(1);
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (start_request)
                begin
                    count_next = COUNT_WIDTH'(cfg.initial_count);
                    steps_next = '0;
                    timer_next = '0;
                    if (stop_request)
                    begin
                        stopped = 1'b1;
                    end
                    else
                    begin
                        phase_next = (cfg.num_steps == '0) ? PH_COMPRESS : PH_ENG_HIGH;
                    end
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        res.engage_pin       = (phase_reg == PH_ENG_HIGH);
        res.disengage_pin    = (phase_reg == PH_DIS_HIGH);
        res.cycle_running    = (phase_reg == PH_ENG_HIGH) || (phase_reg == PH_ENG_LOW)
                               || (phase_reg == PH_COMPRESS) || (phase_reg == PH_DIS_HIGH)
                               || (phase_reg == PH_DIS_LOW);
        res.completed_cycles = OUT_COUNT_WIDTH'(count_next);
        res.count_updated    = updated;
        res.stopped          = stopped;
    end

endmodule
